>>> src/picl_pkg.sv
// Shared types and constants for the PI current loop with built-in current test.
// Holds command and register codes, sequencer states and fixed arithmetic constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package picl_pkg;

  localparam int unsigned TEST_LENGTH_DEF = 100;
  localparam int unsigned INTEG_WIDTH_DEF = 32;

  localparam int unsigned GAIN_W = 16;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_PWM   = 3'd1,
    CMD_TEST  = 3'd2,
    CMD_HOLD  = 3'd3,
    CMD_TRACK = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PWM    = 2'd0,
    REG_KP     = 2'd1,
    REG_KI     = 2'd2,
    REG_PERIOD = 2'd3
  } reg_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INTEG = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_ROUND = 8'b0001_0000,
    S_SCALE = 8'b0010_0000,
    S_RECIP = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  localparam logic [15:0]       PERIOD_RESET = 16'd4000;
  localparam logic signed [8:0] REF_HIGH     = 9'sd200;
  localparam logic signed [8:0] REF_LOW      = -9'sd200;
  localparam logic signed [7:0] PCT_MAX      = 8'sd100;
  localparam logic signed [7:0] PCT_MIN      = -8'sd100;

  // q = (p * RECIP_100) >> RECIP_SHIFT equals p / 100 for every p below 2^23
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_100   = 24'd10737419;

endpackage

`default_nettype wire

>>> src/pi_current_loop_with_test_core.sv
// PI current loop core: idle brake, direct pwm drive and square-wave current test.
// Uses picl_pkg for codes, states and constants. Single module, no submodules.
// A test tick passes integrator, prepare, 16-step shared shift-add multiplier, rounding
// and scaling states before its result; pwm ticks only scale, other ticks go straight to
// the output; ready only in idle state, so a new tick waits for the last result.
// Reset: compare 0, direction 1, test count 0, reference +200, integrator 0,
// registers to pwm 0, gains 0, period 4000; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pi_current_loop_with_test_core #(
  parameter int unsigned TEST_LENGTH      = picl_pkg::TEST_LENGTH_DEF,
  parameter int unsigned INTEGRATOR_WIDTH = picl_pkg::INTEG_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // register write port
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_wdata_i,
  // tick input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         command_i,
  input  wire logic signed [11:0] current_ma_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             compare_value_o,
  output logic                    direction_o,
  output logic signed [8:0]       reference_ma_o,
  output logic [6:0]              sample_index_o,
  output logic                    sample_valid_o,
  output logic                    test_done_o
);

  localparam int unsigned CntW = $clog2(TEST_LENGTH);
  localparam int unsigned IW   = INTEGRATOR_WIDTH;
  localparam int unsigned ErrW = 13;
  // Kp*err + Ki*sum fits in IW+16 signed bits; one extra bit of headroom
  localparam int unsigned AccW = IW + 17;
  localparam int unsigned UW   = AccW - 8;

  localparam logic [CntW-1:0] C_Q1   = CntW'(TEST_LENGTH / 4 - 1);
  localparam logic [CntW-1:0] C_HALF = CntW'(TEST_LENGTH / 2 - 1);
  localparam logic [CntW-1:0] C_Q3   = CntW'((3 * TEST_LENGTH) / 4 - 1);
  localparam logic [CntW-1:0] C_LAST = CntW'(TEST_LENGTH - 1);

  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW - 1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW - 1){1'b0}}};
  localparam logic signed [UW-1:0] U_MAX = UW'(100);
  localparam logic signed [UW-1:0] U_MIN = -UW'(100);
  localparam logic [3:0] BIT_LAST = 4'(picl_pkg::GAIN_W - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers: plain write port; to be written only while idle (not enforced).
  // ---------------------------------------------------------------------------
  logic signed [7:0]  pwm_q;
  logic signed [15:0] kp_q;
  logic signed [15:0] ki_q;
  logic [15:0]        period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q    <= '0;
      kp_q     <= '0;
      ki_q     <= '0;
      period_q <= picl_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (picl_pkg::reg_e'(cfg_index_i))
        picl_pkg::REG_PWM:    pwm_q    <= cfg_wdata_i[7:0];
        picl_pkg::REG_KP:     kp_q     <= cfg_wdata_i;
        picl_pkg::REG_KI:     ki_q     <= cfg_wdata_i;
        picl_pkg::REG_PERIOD: period_q <= cfg_wdata_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  picl_pkg::state_e state_q, state_d;

  // loop state kept across ticks
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic signed [8:0]   ref_q, ref_d;
  logic signed [IW-1:0] sum_q, sum_d;
  logic [15:0]         compare_q, compare_d;
  logic                dir_q, dir_d;

  // per-tick working registers
  logic signed [ErrW-1:0] err_q, err_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW-1:0] e_sh_q, e_sh_d;
  logic signed [AccW-1:0] s_sh_q, s_sh_d;
  logic signed [AccW-1:0] es_sh_q, es_sh_d;
  logic [3:0]             bit_q, bit_d;
  logic signed [7:0]      pct_q, pct_d;
  logic [22:0]            prod_q, prod_d;

  // per-tick result side fields
  logic signed [8:0] item_ref_q, item_ref_d;
  logic [6:0]        item_idx_q, item_idx_d;
  logic              item_valid_q, item_valid_d;
  logic              item_done_q, item_done_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [15:0]       out_cmp_q;
  logic              out_dir_q;
  logic signed [8:0] out_ref_q;
  logic [6:0]        out_idx_q;
  logic              out_svalid_q;
  logic              out_done_q;

  logic in_beat;
  logic out_free;

  assign in_ready_o = (state_q == picl_pkg::S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  // output stage can take a new result when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------------
  // Test sequencing: square wave over TEST_LENGTH ticks, count wraps on the last.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]     cnt_next;
  logic signed [8:0]   ref_next;
  logic                done_next;
  logic [CntW+6:0]     idx_ext;
  logic signed [ErrW-1:0] err_now;
  logic signed [7:0]   pwm_clamped;

  always_comb begin
    cnt_next  = cnt_q + 1'b1;
    ref_next  = ref_q;
    done_next = 1'b0;
    priority if (cnt_q == '0) begin
      ref_next = picl_pkg::REF_HIGH;
    end else if (cnt_q == C_Q1) begin
      ref_next = picl_pkg::REF_LOW;
    end else if (cnt_q == C_HALF) begin
      ref_next = picl_pkg::REF_HIGH;
    end else if (cnt_q == C_Q3) begin
      ref_next = picl_pkg::REF_LOW;
    end else if (cnt_q >= C_LAST) begin
      // last sample: keep reference, wrap and flag the end of the test
      cnt_next  = '0;
      done_next = 1'b1;
    end else begin
      ref_next = ref_q;
    end
  end

  // sample index is the updated count, trimmed or padded to seven bits
  assign idx_ext = {7'b0, cnt_next};
  assign err_now = ErrW'(ref_next) - ErrW'(current_ma_i);

  assign pwm_clamped = (pwm_q > picl_pkg::PCT_MAX) ? picl_pkg::PCT_MAX :
                       (pwm_q < picl_pkg::PCT_MIN) ? picl_pkg::PCT_MIN : pwm_q;

  // ---------------------------------------------------------------------------
  // Arithmetic for the individual steps
  // ---------------------------------------------------------------------------
  logic signed [IW:0]     sum_wide;
  logic signed [IW-1:0]   sum_sat;
  logic signed [AccW-1:0] term;
  logic signed [AccW-1:0] acc_adj;
  logic signed [UW-1:0]   u_raw;
  logic signed [7:0]      u_clamped;
  logic [6:0]             duty;
  logic [46:0]            recip_prod;

  // saturating integrator add
  assign sum_wide = (IW + 1)'(sum_q) + (IW + 1)'(err_q);
  assign sum_sat  = (sum_wide > (IW + 1)'(IMAX)) ? IMAX :
                    (sum_wide < (IW + 1)'(IMIN)) ? IMIN : IW'(sum_wide);

  // shift-add multiplier: one gain bit of each gain per step, MSB weighs negative
  always_comb begin
    unique case ({kp_q[bit_q], ki_q[bit_q]})
      2'b00:   term = '0;
      2'b10:   term = e_sh_q;
      2'b01:   term = s_sh_q;
      default: term = es_sh_q;
    endcase
  end

  // divide by 256 truncating toward zero, then clamp to the percent range
  assign acc_adj   = acc_q[AccW-1] ? acc_q + AccW'(255) : acc_q;
  assign u_raw     = acc_adj[AccW-1:8];
  assign u_clamped = (u_raw > U_MAX) ? picl_pkg::PCT_MAX :
                     (u_raw < U_MIN) ? picl_pkg::PCT_MIN : 8'(u_raw);

  assign duty       = pct_q[7] ? 7'(-pct_q) : 7'(pct_q);
  assign recip_prod = {24'b0, prod_q} * {23'b0, picl_pkg::RECIP_100};

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ref_d        = ref_q;
    sum_d        = sum_q;
    compare_d    = compare_q;
    dir_d        = dir_q;
    err_d        = err_q;
    acc_d        = acc_q;
    e_sh_d       = e_sh_q;
    s_sh_d       = s_sh_q;
    es_sh_d      = es_sh_q;
    bit_d        = bit_q;
    pct_d        = pct_q;
    prod_d       = prod_q;
    item_ref_d   = item_ref_q;
    item_idx_d   = item_idx_q;
    item_valid_d = item_valid_q;
    item_done_d  = item_done_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      picl_pkg::S_IDLE: begin
        if (in_beat) begin
          item_ref_d   = '0;
          item_idx_d   = '0;
          item_valid_d = 1'b0;
          item_done_d  = 1'b0;
          state_d      = picl_pkg::S_OUT;
          unique case (command_i)
            picl_pkg::CMD_IDLE: begin
              // brake: compare to zero, direction holds
              compare_d = '0;
            end
            picl_pkg::CMD_PWM: begin
              pct_d   = pwm_clamped;
              state_d = picl_pkg::S_SCALE;
            end
            picl_pkg::CMD_TEST: begin
              cnt_d        = cnt_next;
              ref_d        = ref_next;
              err_d        = err_now;
              item_ref_d   = ref_next;
              item_idx_d   = idx_ext[6:0];
              item_valid_d = 1'b1;
              item_done_d  = done_next;
              state_d      = picl_pkg::S_INTEG;
            end
            default: begin
              // hold, track and unused codes keep the loop state as is
            end
          endcase
        end
      end

      picl_pkg::S_INTEG: begin
        sum_d   = sum_sat;
        e_sh_d  = AccW'(err_q);
        s_sh_d  = AccW'(sum_sat);
        state_d = picl_pkg::S_PREP;
      end

      picl_pkg::S_PREP: begin
        es_sh_d = e_sh_q + s_sh_q;
        acc_d   = '0;
        bit_d   = '0;
        state_d = picl_pkg::S_MUL;
      end

      picl_pkg::S_MUL: begin
        acc_d   = (bit_q == BIT_LAST) ? acc_q - term : acc_q + term;
        e_sh_d  = e_sh_q <<< 1;
        s_sh_d  = s_sh_q <<< 1;
        es_sh_d = es_sh_q <<< 1;
        bit_d   = bit_q + 1'b1;
        if (bit_q == BIT_LAST) begin
          state_d = picl_pkg::S_ROUND;
        end
      end

      picl_pkg::S_ROUND: begin
        pct_d   = u_clamped;
        state_d = picl_pkg::S_SCALE;
      end

      picl_pkg::S_SCALE: begin
        dir_d   = pct_q[7];
        prod_d  = {16'b0, duty} * {7'b0, period_q};
        state_d = picl_pkg::S_RECIP;
      end

      picl_pkg::S_RECIP: begin
        compare_d = recip_prod[picl_pkg::RECIP_SHIFT +: 16];
        state_d   = picl_pkg::S_OUT;
      end

      picl_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = picl_pkg::S_IDLE;
        end
      end

      default: state_d = picl_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= picl_pkg::S_IDLE;
      cnt_q       <= '0;
      ref_q       <= picl_pkg::REF_HIGH;
      sum_q       <= '0;
      compare_q   <= '0;
      dir_q       <= 1'b1;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ref_q       <= ref_d;
      sum_q       <= sum_d;
      compare_q   <= compare_d;
      dir_q       <= dir_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q        <= err_d;
    acc_q        <= acc_d;
    e_sh_q       <= e_sh_d;
    s_sh_q       <= s_sh_d;
    es_sh_q      <= es_sh_d;
    pct_q        <= pct_d;
    prod_q       <= prod_d;
    item_ref_q   <= item_ref_d;
    item_idx_q   <= item_idx_d;
    item_valid_q <= item_valid_d;
    item_done_q  <= item_done_d;
    // load the output beat when the result leaves the sequencer
    if (state_q == picl_pkg::S_OUT && out_free) begin
      out_cmp_q    <= compare_q;
      out_dir_q    <= dir_q;
      out_ref_q    <= item_ref_q;
      out_idx_q    <= item_idx_q;
      out_svalid_q <= item_valid_q;
      out_done_q   <= item_done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign compare_value_o = out_cmp_q;
  assign direction_o     = out_dir_q;
  assign reference_ma_o  = out_ref_q;
  assign sample_index_o  = out_idx_q;
  assign sample_valid_o  = out_svalid_q;
  assign test_done_o     = out_done_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= C_LAST)
    else $error("test count beyond test length");

  a_test_enters_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && command_i == picl_pkg::CMD_TEST) |=> state_q == picl_pkg::S_INTEG)
    else $error("test beat did not start the integrator step");

  a_mul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == picl_pkg::S_MUL && bit_q == BIT_LAST) |=> state_q == picl_pkg::S_ROUND)
    else $error("multiplier did not stop after the last gain bit");

  a_sample_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_valid_o) |->
      (reference_ma_o == picl_pkg::REF_HIGH || reference_ma_o == picl_pkg::REF_LOW))
    else $error("test sample with reference other than plus or minus 200");

endmodule

`default_nettype wire
